### rtl/wtg_pkg.sv
// ----------------------------------------------------------------------------
// Waveform table generator package
// Shared constants, codes, controller/datapath interface types and the
// quarter-wave sine table used by the waveform table generator.
// ----------------------------------------------------------------------------
package wtg_pkg;

    // Table and accumulator sizes.
    localparam int MAX_TABLE_LENGTH = 256;
    localparam int POS_W            = $clog2(MAX_TABLE_LENGTH);
    localparam int LEN_W            = 9;
    localparam int LEVEL_W          = 8;
    localparam int ACC_W            = 24;
    localparam int TIME_W           = 16;
    localparam int MASK_W           = 4;

    // Sine table geometry.
    localparam int SINE_TABLE_SIZE  = 256;
    localparam int QUARTER_SIZE     = SINE_TABLE_SIZE / 4;
    localparam int SINE_IDX_W       = $clog2(SINE_TABLE_SIZE);
    localparam int QTR_IDX_W        = $clog2(QUARTER_SIZE + 1);
    localparam int SINE_W           = 15;

    // Serial divider geometry: dividend of up to 2^24, divisor of up to 256.
    localparam int DIV_N_W          = ACC_W + 1;
    localparam int DIV_D_W          = LEN_W;
    localparam int DIV_CNT_W        = $clog2(DIV_N_W + 1);

    // Configuration port.
    localparam int CFG_INDEX_W      = 3;
    localparam int CFG_DATA_W       = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_WAVE_KIND    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_LEVEL    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LEVEL    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TABLE_LENGTH = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_MASK = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_TIME    = 3'd5;

    // Waveform codes.
    typedef enum logic [1:0] {
        WAVE_TRIANGLE = 2'd0,
        WAVE_SAW      = 2'd1,
        WAVE_RAMP     = 2'd2,
        WAVE_SINE     = 2'd3
    } wave_kind_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_DIV_PHASE,
        ST_DIV_LEVEL,
        ST_LOOKUP,
        ST_UPDATE,
        ST_EMIT
    } wtg_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic start_item;
        logic div_phase_go;
        logic store_phase;
        logic store_level;
        logic lookup;
        logic update;
        logic emit;
    } wtg_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic entry_zero;
        logic div_done;
        logic out_free;
    } wtg_status_t;

    // Quarter-wave sine table, unsigned Q0.15, entries 0 to QUARTER_SIZE.
    typedef logic [SINE_W-1:0] sine_tab_t [0:QUARTER_SIZE];

    function automatic sine_tab_t build_sine_tab();
        sine_tab_t tab;
        longint    x;
        longint    x2;
        longint    inner;
        longint    poly;
        longint    r;
        for (int k = 0; k <= QUARTER_SIZE; k++) begin
            x     = (longint'(k) << 16) / QUARTER_SIZE;
            x2    = (x * x) >> 16;
            inner = 42047 - ((4640 * x2) >> 16);
            poly  = 102944 - ((x2 * inner) >> 16);
            r     = (x * poly) >> 16;
            r     = (r + 1) >> 1;
            if (r > 32767) begin
                r = 32767;
            end
            tab[k] = SINE_W'(r);
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_QTR = build_sine_tab();

endpackage

### rtl/waveform_table_generator.sv
// ----------------------------------------------------------------------------
// Waveform table generator
// Top level: each input word yields the next entry of a colour-animation
// table following a triangle, sawtooth, ramp or sine waveform.
// ----------------------------------------------------------------------------
// Each accepted word (restart bit) produces exactly one output word holding
// the level in every enabled colour channel, the step time, the entry index
// and an end-of-table mark. Words are handled one at a time. An ordinary
// entry runs through the controller sequence of lookup, level update and
// hand-over before the next word can be taken. The first entry of a table,
// whether forced by restart or reached after the last entry, additionally
// runs two 25-step serial divisions for the phase and level increments.
// The output register holds a finished word while the next input word is
// taken and worked on. Configuration writes take effect at once and are
// meant to be made while no word is in progress; lowest and highest level
// affect the level waveforms only from the start of the next table.
module waveform_table_generator
    import wtg_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_wr_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_restart,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [LEVEL_W-1:0]     m_red,
    output logic [LEVEL_W-1:0]     m_green,
    output logic [LEVEL_W-1:0]     m_blue,
    output logic [LEVEL_W-1:0]     m_alpha,
    output logic [TIME_W-1:0]      m_entry_time,
    output logic [POS_W-1:0]       m_entry_index,
    output logic                   m_last
);

    wtg_cmd_t    cmd;
    wtg_status_t status;

    // Sequencer.
    wtg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Arithmetic, state and output register.
    wtg_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_index  (cfg_wr_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_restart     (s_restart),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_red         (m_red),
        .m_green       (m_green),
        .m_blue        (m_blue),
        .m_alpha       (m_alpha),
        .m_entry_time  (m_entry_time),
        .m_entry_index (m_entry_index),
        .m_last        (m_last),
        .cmd           (cmd),
        .status        (status)
    );

endmodule

### rtl/wtg_div.sv
// ----------------------------------------------------------------------------
// Waveform table generator serial divider
// Unsigned restoring divider that produces one quotient bit per cycle and
// pulses done when the quotient is complete.
// ----------------------------------------------------------------------------
module wtg_div
    import wtg_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               go,
    input  logic [DIV_N_W-1:0] dividend,
    input  logic [DIV_D_W-1:0] divisor,
    output logic [ACC_W-1:0]   quotient,
    output logic               done
);

    logic [DIV_N_W-1:0]   dvd_reg,  dvd_next;
    logic [DIV_N_W-1:0]   quo_reg,  quo_next;
    logic [DIV_D_W-1:0]   rem_reg,  rem_next;
    logic [DIV_D_W-1:0]   dsr_reg,  dsr_next;
    logic [DIV_CNT_W-1:0] cnt_reg,  cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [DIV_D_W:0]     trial;
    logic                 fits;

    // One restoring step: bring down the next dividend bit and try to subtract.
    always_comb begin
        trial     = {rem_reg, dvd_reg[DIV_N_W-1]};
        fits      = (trial >= {1'b0, dsr_reg});
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (go) begin
            dvd_next  = dividend;
            quo_next  = '0;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = DIV_CNT_W'(DIV_N_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            dvd_next  = {dvd_reg[DIV_N_W-2:0], 1'b0};
            quo_next  = {quo_reg[DIV_N_W-2:0], fits};
            rem_next  = fits ? DIV_D_W'(trial - {1'b0, dsr_reg}) : DIV_D_W'(trial);
            cnt_next  = cnt_reg - 1'b1;
            busy_next = (cnt_reg != DIV_CNT_W'(1));
            done_next = (cnt_reg == DIV_CNT_W'(1));
        end
    end

    // Control state is reset; the working registers are not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        cnt_reg <= cnt_next;
    end

    assign quotient = quo_reg[ACC_W-1:0];
    assign done     = done_reg;

endmodule

### rtl/wtg_ctrl.sv
// ----------------------------------------------------------------------------
// Waveform table generator controller
// State machine that accepts an input word, sequences the step divisions at
// the start of a table, the level calculation and the hand-over of the result.
// ----------------------------------------------------------------------------
module wtg_ctrl
    import wtg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  wtg_status_t status,
    output wtg_cmd_t    cmd
);

    wtg_state_t state_reg, state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                state_next = status.entry_zero ? ST_DIV_PHASE : ST_LOOKUP;
            end
            ST_DIV_PHASE: begin
                if (status.div_done) begin
                    state_next = ST_DIV_LEVEL;
                end
            end
            ST_DIV_LEVEL: begin
                if (status.div_done) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_START: begin
                cmd.start_item   = 1'b1;
                cmd.div_phase_go = status.entry_zero;
            end
            ST_DIV_PHASE: begin
                cmd.store_phase = status.div_done;
            end
            ST_DIV_LEVEL: begin
                cmd.store_level = status.div_done;
            end
            ST_LOOKUP: begin
                cmd.lookup = 1'b1;
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
            end
            ST_EMIT: begin
                cmd.emit = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

### rtl/wtg_dp.sv
// ----------------------------------------------------------------------------
// Waveform table generator datapath
// Configuration registers, table position, level accumulator, step
// registers, sine lookup, level calculation and the output register.
// ----------------------------------------------------------------------------
module wtg_dp
    import wtg_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_wr_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                   s_restart,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [LEVEL_W-1:0]     m_red,
    output logic [LEVEL_W-1:0]     m_green,
    output logic [LEVEL_W-1:0]     m_blue,
    output logic [LEVEL_W-1:0]     m_alpha,
    output logic [TIME_W-1:0]      m_entry_time,
    output logic [POS_W-1:0]       m_entry_index,
    output logic                   m_last,
    input  wtg_cmd_t               cmd,
    output wtg_status_t            status
);

    // Configuration registers.
    wave_kind_t         kind_reg;
    logic [LEVEL_W-1:0] min_reg;
    logic [LEVEL_W-1:0] max_reg;
    logic [LEN_W-1:0]   length_reg;
    logic [MASK_W-1:0]  mask_reg;
    logic [TIME_W-1:0]  time_reg;

    // Generator state.
    logic [POS_W-1:0]   position_reg, position_next;
    logic [ACC_W-1:0]   acc_reg,      acc_next;
    logic [ACC_W-1:0]   lstep_reg,    lstep_next;
    logic [ACC_W-1:0]   pstep_reg,    pstep_next;
    logic               restart_reg;
    logic signed [15:0] sine_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic [POS_W-1:0]   idx_reg;
    logic               last_reg;

    // Output register.
    logic               m_valid_reg,  m_valid_next;
    logic [LEVEL_W-1:0] red_reg, green_reg, blue_reg, alpha_reg;
    logic [TIME_W-1:0]  etime_reg;
    logic [POS_W-1:0]   eindex_reg;
    logic               elast_reg;

    // Derived configuration values.
    logic [LEN_W-1:0]   len;
    logic               len_short;
    logic [LEVEL_W-1:0] lo;
    logic [LEVEL_W-1:0] hi;
    logic [LEVEL_W-1:0] d;

    // Divider connections.
    logic               div_go;
    logic [DIV_N_W-1:0] div_dividend;
    logic [DIV_D_W-1:0] div_divisor;
    logic [ACC_W-1:0]   div_quotient;
    logic               div_done;

    // Sine lookup.
    logic [31:0]              ang_scaled;
    logic [SINE_IDX_W-1:0]    circ_idx;
    logic [1:0]               quad;
    logic [QTR_IDX_W-1:0]     qtr_k;
    logic [QTR_IDX_W-1:0]     qtr_sel;
    logic signed [15:0]       sine_mag;

    // Level calculation.
    logic [LEVEL_W:0]         lvl_sum;
    logic signed [24:0]       sine_prod;
    logic signed [25:0]       sine_mix;
    logic [LEVEL_W-1:0]       sine_level;
    logic [ACC_W:0]           acc_up;
    logic [ACC_W:0]           acc_dn;
    logic                     go_up;
    logic                     is_last;

    // Effective length: zero counts as one, long tables saturate.
    always_comb begin
        len = length_reg;
        if (length_reg == '0) begin
            len = LEN_W'(1);
        end else if (length_reg > LEN_W'(MAX_TABLE_LENGTH)) begin
            len = LEN_W'(MAX_TABLE_LENGTH);
        end
        len_short = (len < LEN_W'(2));
        lo        = min_reg;
        hi        = (max_reg < min_reg) ? min_reg : max_reg;
        d         = hi - lo;
    end

    // Status towards the controller. A table starts on restart, at position
    // zero, or when the position has fallen beyond a shortened table.
    assign status.entry_zero = restart_reg || (position_reg == '0) ||
                               ({{(LEN_W-POS_W){1'b0}}, position_reg} >= len);
    assign status.div_done   = div_done;
    assign status.out_free   = !m_valid_reg || m_ready;

    // The phase division starts the item; the level division follows it.
    assign div_go = cmd.div_phase_go || cmd.store_phase;

    always_comb begin
        if (cmd.div_phase_go) begin
            div_dividend = DIV_N_W'(1) << ACC_W;
            div_divisor  = len;
        end else begin
            div_dividend = {1'b0, d, 16'b0};
            div_divisor  = (kind_reg == WAVE_TRIANGLE) ? (len >> 1) : (len - 1'b1);
        end
    end

    wtg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .go       (div_go),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .done     (div_done)
    );

    // Sine of the phase: quadrant folding of the quarter-wave table.
    always_comb begin
        ang_scaled = {16'b0, acc_reg[ACC_W-1:8]} * 32'(SINE_TABLE_SIZE);
        circ_idx   = ang_scaled[16 +: SINE_IDX_W];
        quad       = 2'(circ_idx / QUARTER_SIZE);
        qtr_k      = QTR_IDX_W'(circ_idx % QUARTER_SIZE);
        qtr_sel    = quad[0] ? (QTR_IDX_W'(QUARTER_SIZE) - qtr_k) : qtr_k;
        sine_mag   = {1'b0, SINE_QTR[qtr_sel]};
    end

    // Level for the sine: midpoint plus half-range times the sine.
    always_comb begin
        lvl_sum   = {1'b0, hi} + {1'b0, lo};
        sine_prod = $signed({1'b0, d}) * sine_reg;
        sine_mix  = $signed({2'b0, lvl_sum, 15'b0}) + {sine_prod[24], sine_prod};
        if (sine_mix[25]) begin
            sine_level = '0;
        end else if (sine_mix[24]) begin
            sine_level = '1;
        end else begin
            sine_level = sine_mix[23:16];
        end
    end

    // Accumulator moves and end-of-table detection.
    always_comb begin
        acc_up  = {1'b0, acc_reg} + {1'b0, lstep_reg};
        acc_dn  = {1'b0, acc_reg} - {1'b0, lstep_reg};
        go_up   = (kind_reg == WAVE_RAMP) ||
                  ((kind_reg == WAVE_TRIANGLE) &&
                   ({{(LEN_W-POS_W){1'b0}}, position_reg} < (len >> 1)));
        is_last = ({{(LEN_W-POS_W){1'b0}}, position_reg} == (len - 1'b1));
    end

    // Next values of the generator state.
    always_comb begin
        position_next = position_reg;
        acc_next      = acc_reg;
        lstep_next    = lstep_reg;
        pstep_next    = pstep_reg;
        if (cmd.start_item && status.entry_zero) begin
            position_next = '0;
        end
        if (cmd.store_phase) begin
            pstep_next = len_short ? '0 : div_quotient;
        end
        if (cmd.store_level) begin
            lstep_next = len_short ? '0 : div_quotient;
            if (kind_reg == WAVE_SINE) begin
                acc_next = '0;
            end else if ((kind_reg == WAVE_SAW) && !len_short) begin
                acc_next = {hi, 16'b0};
            end else begin
                acc_next = {lo, 16'b0};
            end
        end
        if (cmd.update) begin
            position_next = is_last ? '0 : position_reg + 1'b1;
            if (kind_reg == WAVE_SINE) begin
                acc_next = acc_reg + pstep_reg;
            end else if (go_up) begin
                acc_next = acc_up[ACC_W] ? '1 : acc_up[ACC_W-1:0];
            end else begin
                acc_next = acc_dn[ACC_W] ? '0 : acc_dn[ACC_W-1:0];
            end
        end
    end

    // Configuration writes and generator state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg     <= WAVE_TRIANGLE;
            min_reg      <= '0;
            max_reg      <= LEVEL_W'(255);
            length_reg   <= LEN_W'(256);
            mask_reg     <= MASK_W'(4'h0f);
            time_reg     <= TIME_W'(200);
            position_reg <= '0;
            acc_reg      <= '0;
            lstep_reg    <= '0;
            pstep_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_wr_index)
                    CFG_WAVE_KIND:    kind_reg   <= wave_kind_t'(cfg_wr_data[1:0]);
                    CFG_MIN_LEVEL:    min_reg    <= cfg_wr_data[LEVEL_W-1:0];
                    CFG_MAX_LEVEL:    max_reg    <= cfg_wr_data[LEVEL_W-1:0];
                    CFG_TABLE_LENGTH: length_reg <= cfg_wr_data[LEN_W-1:0];
                    CFG_CHANNEL_MASK: mask_reg   <= cfg_wr_data[MASK_W-1:0];
                    CFG_STEP_TIME:    time_reg   <= cfg_wr_data[TIME_W-1:0];
                    default: begin
                    end
                endcase
            end
            position_reg <= position_next;
            acc_reg      <= acc_next;
            lstep_reg    <= lstep_next;
            pstep_reg    <= pstep_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Output word handshake.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Payload registers: captured input, lookup, level and output word.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            restart_reg <= s_restart;
        end
        if (cmd.lookup) begin
            sine_reg <= quad[1] ? -sine_mag : sine_mag;
        end
        if (cmd.update) begin
            level_reg <= (kind_reg == WAVE_SINE) ? sine_level : acc_reg[ACC_W-1 -: LEVEL_W];
            idx_reg   <= position_reg;
            last_reg  <= is_last;
        end
        if (cmd.emit) begin
            red_reg    <= mask_reg[0] ? level_reg : '0;
            green_reg  <= mask_reg[1] ? level_reg : '0;
            blue_reg   <= mask_reg[2] ? level_reg : '0;
            alpha_reg  <= mask_reg[3] ? level_reg : '0;
            etime_reg  <= time_reg;
            eindex_reg <= idx_reg;
            elast_reg  <= last_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_red         = red_reg;
    assign m_green       = green_reg;
    assign m_blue        = blue_reg;
    assign m_alpha       = alpha_reg;
    assign m_entry_time  = etime_reg;
    assign m_entry_index = eindex_reg;
    assign m_last        = elast_reg;

endmodule

### tb/tb_waveform_table_generator.sv
// ----------------------------------------------------------------------------
// Waveform table generator testbench
// Drives restart words into the generator under changing register settings
// and compares every output word with a cycle-free table-entry predictor.
// ----------------------------------------------------------------------------
module tb_waveform_table_generator;
    timeunit 1ns;
    timeprecision 1ps;

    import wtg_pkg::*;

    localparam int CLOCK_LIMIT  = 600000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 150;
    localparam int RANDOM_WORDS = 1750;
    localparam int ACC_LIMIT    = 24'hFFFFFF;

    // One table entry as it leaves the block.
    typedef struct packed {
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
        logic [LEVEL_W-1:0] alpha;
        logic [TIME_W-1:0]  etime;
        logic [POS_W-1:0]   eidx;
        logic               last;
    } table_entry_t;

    logic                   aclk          = 1'b0;
    logic                   aresetn       = 1'b0;
    logic                   cfg_wr_en     = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_wr_index  = '0;
    logic [CFG_DATA_W-1:0]  cfg_wr_data   = '0;
    logic                   s_valid       = 1'b0;
    logic                   s_ready;
    logic                   s_restart     = 1'b0;
    logic                   m_valid;
    logic                   m_ready       = 1'b0;
    logic [LEVEL_W-1:0]     m_red;
    logic [LEVEL_W-1:0]     m_green;
    logic [LEVEL_W-1:0]     m_blue;
    logic [LEVEL_W-1:0]     m_alpha;
    logic [TIME_W-1:0]      m_entry_time;
    logic [POS_W-1:0]       m_entry_index;
    logic                   m_last;

    waveform_table_generator dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_index  (cfg_wr_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_restart     (s_restart),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_red         (m_red),
        .m_green       (m_green),
        .m_blue        (m_blue),
        .m_alpha       (m_alpha),
        .m_entry_time  (m_entry_time),
        .m_entry_index (m_entry_index),
        .m_last        (m_last)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Register copies held by the predictor.
    wave_kind_t          cur_kind = WAVE_TRIANGLE;
    logic [LEVEL_W-1:0]  cur_min  = 8'd0;
    logic [LEVEL_W-1:0]  cur_max  = 8'd255;
    logic [LEN_W-1:0]    cur_len  = 9'd256;
    logic [MASK_W-1:0]   cur_mask = 4'hF;
    logic [TIME_W-1:0]   cur_time = 16'd200;

    // Predictor state.
    int unsigned next_pos  = 0;
    longint      level_acc = 0;
    longint      level_inc = 0;
    longint      phase_inc = 0;

    bit            restart_q[$];
    table_entry_t  entry_q[$];
    int            fail_cnt       = 0;
    int            send_idle_pct  = 0;
    int            recv_stall_pct = 0;
    logic          in_taken       = 1'b0;
    bit            hold_arm       = 1'b0;
    bit            hold_used      = 1'b0;
    int            hold_cnt       = 0;
    int            cycles         = 0;

    // Quarter-wave sine entry in Q1.15 from the polynomial approximation.
    function automatic longint quarter_wave(int unsigned k);
        longint x;
        longint x2;
        longint inner;
        longint poly;
        longint r;
        x     = (longint'(k) << 16) / QUARTER_SIZE;
        x2    = (x * x) >> 16;
        inner = 42047 - ((4640 * x2) >> 16);
        poly  = 102944 - ((x2 * inner) >> 16);
        r     = (((x * poly) >> 16) + 1) >> 1;
        return (r > 32767) ? 32767 : r;
    endfunction

    // Signed sine of a 16-bit angle, folded from the quarter wave.
    function automatic longint sine_value(logic [15:0] angle);
        int unsigned i;
        int unsigned quad;
        int unsigned k;
        longint      v;
        i    = (int'(angle) * (4 * QUARTER_SIZE)) >> 16;
        quad = (i / QUARTER_SIZE) & 3;
        k    = i % QUARTER_SIZE;
        v    = quad[0] ? quarter_wave(QUARTER_SIZE - k) : quarter_wave(k);
        return quad[1] ? -v : v;
    endfunction

    // Works out the table entry that one accepted word produces.
    function automatic table_entry_t next_table_entry(logic restart);
        int unsigned  len;
        int unsigned  idx;
        longint       lo;
        longint       hi;
        longint       d;
        longint       v;
        longint       level;
        logic         up;
        table_entry_t e;
        len = (cur_len == 0) ? 1 : ((cur_len > MAX_TABLE_LENGTH) ? MAX_TABLE_LENGTH : cur_len);
        lo  = cur_min;
        hi  = (cur_max < cur_min) ? cur_min : cur_max;
        d   = hi - lo;
        if (restart || next_pos >= len) begin
            next_pos = 0;
        end
        // Increments and the starting level are latched at entry zero.
        if (next_pos == 0) begin
            phase_inc = (len >= 2) ? (longint'(1) << 24) / len : 0;
            if (len < 2) begin
                level_inc = 0;
            end else if (cur_kind == WAVE_TRIANGLE) begin
                level_inc = (d << 16) / (len / 2);
            end else begin
                level_inc = (d << 16) / (len - 1);
            end
            if (cur_kind == WAVE_SINE) begin
                level_acc = 0;
            end else if (cur_kind == WAVE_SAW && len >= 2) begin
                level_acc = hi << 16;
            end else begin
                level_acc = lo << 16;
            end
        end
        idx = next_pos;
        if (cur_kind == WAVE_SINE) begin
            v = (hi + lo) * 32768 + d * sine_value(level_acc[23:8]);
            if (v < 0) begin
                v = 0;
            end
            v         = v >> 16;
            level     = (v > 255) ? 255 : v;
            level_acc = (level_acc + phase_inc) & ACC_LIMIT;
        end else begin
            level = level_acc >> 16;
            if (level > 255) begin
                level = 255;
            end
            up = (cur_kind == WAVE_RAMP) || (cur_kind == WAVE_TRIANGLE && idx < len / 2);
            level_acc = up ? level_acc + level_inc : level_acc - level_inc;
            if (level_acc < 0) begin
                level_acc = 0;
            end
            if (level_acc > ACC_LIMIT) begin
                level_acc = ACC_LIMIT;
            end
        end
        e.last   = (idx == len - 1);
        next_pos = e.last ? 0 : idx + 1;
        e.red    = cur_mask[0] ? level[7:0] : '0;
        e.green  = cur_mask[1] ? level[7:0] : '0;
        e.blue   = cur_mask[2] ? level[7:0] : '0;
        e.alpha  = cur_mask[3] ? level[7:0] : '0;
        e.etime  = cur_time;
        e.eidx   = idx[POS_W-1:0];
        return e;
    endfunction

    function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            fail_cnt++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    // Input word acceptance, prediction and output word checking.
    always @(posedge aclk) begin : monitor
        table_entry_t want;
        in_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            entry_q.push_back(next_table_entry(s_restart));
        end
        if (aresetn && m_valid && m_ready) begin
            if (entry_q.size() == 0) begin
                fail_cnt++;
                $display("%0t ns: output word with none expected, index %0d", $time,
                         m_entry_index);
            end else begin
                want = entry_q.pop_front();
                compare_field("red", want.red, m_red);
                compare_field("green", want.green, m_green);
                compare_field("blue", want.blue, m_blue);
                compare_field("alpha", want.alpha, m_alpha);
                compare_field("entry_time", want.etime, m_entry_time);
                compare_field("entry_index", want.eidx, m_entry_index);
                compare_field("last", want.last, m_last);
            end
        end
    end

    // Sender: holds a word until taken, otherwise offers the next or idles.
    always @(negedge aclk) begin : feeder
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !in_taken) begin
            s_valid <= 1'b1;
        end else if (restart_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            s_valid   <= 1'b1;
            s_restart <= restart_q.pop_front();
        end else begin
            s_valid <= 1'b0;
        end
    end

    // Receiver: random stalls, or a long hold-off while the timer runs.
    always @(negedge aclk) begin : receiver
        if (!aresetn || hold_cnt != 0) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Long hold-off timer, started once on request.
    always @(posedge aclk) begin : hold_timer
        if (hold_arm && !hold_used) begin
            hold_cnt  <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    // Run limit.
    always @(posedge aclk) begin : watchdog
        cycles <= cycles + 1;
        if (cycles == CLOCK_LIMIT) begin
            $display("tb_waveform_table_generator NOT OK");
            $finish;
        end
    end

    // Register write, mirrored into the predictor's copy at once.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned value);
        @(negedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= CFG_DATA_W'(value);
        case (idx)
            CFG_WAVE_KIND:    cur_kind = wave_kind_t'(value[1:0]);
            CFG_MIN_LEVEL:    cur_min  = value[7:0];
            CFG_MAX_LEVEL:    cur_max  = value[7:0];
            CFG_TABLE_LENGTH: cur_len  = value[8:0];
            CFG_CHANNEL_MASK: cur_mask = value[3:0];
            CFG_STEP_TIME:    cur_time = value[15:0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic queue_words(input int n, input int restart_pct);
        for (int i = 0; i < n; i++) begin
            restart_q.push_back($urandom_range(99) < restart_pct);
        end
    endtask

    // Waits until every word has been taken and every entry has come back.
    task automatic wait_drained();
        while (restart_q.size() != 0 || s_valid || entry_q.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    function automatic int unsigned pick_level();
        case ($urandom_range(7))
            0:       return 0;
            1:       return 255;
            default: return $urandom_range(255);
        endcase
    endfunction

    function automatic int unsigned pick_length();
        int unsigned edges[7] = '{0, 1, 2, 255, 256, 257, 511};
        int          r;
        r = $urandom_range(99);
        if (r < 60) begin
            return $urandom_range(12, 1);
        end else if (r < 85) begin
            return $urandom_range(256, 13);
        end
        return edges[$urandom_range(6)];
    endfunction

    function automatic int unsigned pick_time();
        int unsigned edges[3] = '{0, 1, 65535};
        if ($urandom_range(9) == 0) begin
            return edges[$urandom_range(2)];
        end
        return $urandom_range(65535);
    endfunction

    // Rewrites a random subset of the registers.
    task automatic shuffle_settings();
        if ($urandom_range(3) != 0) write_reg(CFG_WAVE_KIND, $urandom_range(3));
        if ($urandom_range(3) != 0) write_reg(CFG_MIN_LEVEL, pick_level());
        if ($urandom_range(3) != 0) write_reg(CFG_MAX_LEVEL, pick_level());
        if ($urandom_range(3) != 0) write_reg(CFG_TABLE_LENGTH, pick_length());
        if ($urandom_range(3) != 0) write_reg(CFG_CHANNEL_MASK, $urandom_range(15));
        if ($urandom_range(3) != 0) write_reg(CFG_STEP_TIME, pick_time());
        end_writes();
    endtask

    initial begin : sequencer
        int sent;
        int phase;
        int n;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset settings: full-range triangle over 256 entries.
        restart_q = '{1, 0, 0, 0};
        wait_drained();

        // A length of zero acts as one: a single entry at the lowest level.
        write_reg(CFG_WAVE_KIND, WAVE_SAW);
        write_reg(CFG_TABLE_LENGTH, 0);
        end_writes();
        restart_q = '{1, 0};
        wait_drained();

        // A one-entry sine table gives the midpoint.
        write_reg(CFG_WAVE_KIND, WAVE_SINE);
        write_reg(CFG_MIN_LEVEL, 40);
        write_reg(CFG_MAX_LEVEL, 200);
        write_reg(CFG_TABLE_LENGTH, 1);
        end_writes();
        restart_q = '{0, 0};
        wait_drained();

        // Highest level below lowest, zero step time, running past the end.
        write_reg(CFG_WAVE_KIND, WAVE_RAMP);
        write_reg(CFG_MIN_LEVEL, 200);
        write_reg(CFG_MAX_LEVEL, 10);
        write_reg(CFG_TABLE_LENGTH, 4);
        write_reg(CFG_STEP_TIME, 0);
        end_writes();
        restart_q = '{0, 0, 0, 0, 0};
        wait_drained();

        // All channels masked, then the table shrunk below the position.
        write_reg(CFG_WAVE_KIND, WAVE_TRIANGLE);
        write_reg(CFG_MIN_LEVEL, 0);
        write_reg(CFG_MAX_LEVEL, 255);
        write_reg(CFG_TABLE_LENGTH, 8);
        write_reg(CFG_CHANNEL_MASK, 0);
        write_reg(CFG_STEP_TIME, 65535);
        end_writes();
        restart_q = '{1, 0, 0};
        wait_drained();
        write_reg(CFG_TABLE_LENGTH, 2);
        write_reg(CFG_CHANNEL_MASK, 4'b1010);
        end_writes();
        restart_q = '{0};
        wait_drained();

        // Oversized length saturates; then a four-entry sine visits each quadrant.
        write_reg(CFG_WAVE_KIND, WAVE_SINE);
        write_reg(CFG_TABLE_LENGTH, 511);
        write_reg(CFG_CHANNEL_MASK, 15);
        write_reg(CFG_STEP_TIME, 1);
        end_writes();
        restart_q = '{1, 0, 0};
        wait_drained();
        write_reg(CFG_TABLE_LENGTH, 4);
        end_writes();
        restart_q = '{1, 0, 0, 0};
        wait_drained();

        // Random phases with changing settings and traffic patterns.
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_WORDS) begin
            case (phase % 5)
                1:       begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 79; end
                3:       begin send_idle_pct = 30; recv_stall_pct = 30; end
                default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            endcase
            shuffle_settings();
            n = $urandom_range(60, 10);
            // Receiver held off so the block fills and stalls its input.
            if (phase == 5) begin
                n        = 60;
                hold_arm = 1'b1;
            end
            queue_words(n, 6);
            wait_drained();
            sent += n;
            phase++;
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_cnt == 0) begin
            $display("tb_waveform_table_generator OK");
        end else begin
            $display("tb_waveform_table_generator NOT OK");
        end
        $finish;
    end

endmodule
